// ===== design/qvr_pkg.sv =====
package qvr_pkg;

    localparam int VW  = 16;
    localparam int QW  = 17;
    localparam int PW  = 33;
    localparam int NW  = 34;
    localparam int DSW = 35;
    localparam int CW  = 34;
    localparam int M2W = 52;
    localparam int SW  = 56;
    localparam int AW  = 58;
    localparam int DW  = 35;
    localparam int QB  = 18;
    localparam int OW  = 17;
    localparam int LANES = 3;

    localparam logic [VW-1:0] QUAT_W_RST = 16'sd16384;

    typedef enum logic [1:0] {
        REG_QW = 2'd0,
        REG_QX = 2'd1,
        REG_QY = 2'd2,
        REG_QZ = 2'd3
    } t_reg_idx;

    typedef logic [AW-1:0] t_rem;
    typedef logic [QB-1:0] t_quo;

endpackage

// ===== design/qvr_divider.sv =====
module qvr_divider (
    input  logic                     i_clk,
    input  logic [qvr_pkg::QB-1:0]   i_ce,
    input  qvr_pkg::t_rem            i_num [qvr_pkg::LANES],
    input  logic [qvr_pkg::DW-1:0]   i_den,
    input  logic [qvr_pkg::LANES-1:0] i_neg,
    input  logic                     i_nz,
    output qvr_pkg::t_quo            o_quo [qvr_pkg::LANES],
    output logic [qvr_pkg::LANES-1:0] o_neg,
    output logic                     o_nz
);
    import qvr_pkg::*;

    t_rem              r_rem [QB][LANES];
    t_quo              r_quo [QB][LANES];
    logic [DW-1:0]     r_den [QB];
    logic [LANES-1:0]  r_neg [QB];
    logic              r_nz  [QB];

    for (genvar j = 0; j < QB; j++) begin : g_stage
        logic [AW-1:0] w_dsh;
        t_rem          w_rin [LANES];
        t_quo          w_qin [LANES];
        logic [DW-1:0] w_den;

        assign w_den = (j == 0) ? i_den : r_den[(j == 0) ? 0 : j-1];
        assign w_dsh = {{(AW-DW){1'b0}}, w_den} << (QB-1-j);

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign w_rin[l] = (j == 0) ? i_num[l] : r_rem[(j == 0) ? 0 : j-1][l];
            assign w_qin[l] = (j == 0) ? '0 : r_quo[(j == 0) ? 0 : j-1][l];
        end

        always_ff @(posedge i_clk) begin
            if (i_ce[j]) begin
                r_den[j] <= w_den;
                r_neg[j] <= (j == 0) ? i_neg : r_neg[(j == 0) ? 0 : j-1];
                r_nz[j]  <= (j == 0) ? i_nz : r_nz[(j == 0) ? 0 : j-1];
                for (int l = 0; l < LANES; l++) begin
                    if (w_rin[l] >= w_dsh) begin
                        r_rem[j][l] <= w_rin[l] - w_dsh;
                        r_quo[j][l] <= w_qin[l] | (t_quo'(1) << (QB-1-j));
                    end else begin
                        r_rem[j][l] <= w_rin[l];
                        r_quo[j][l] <= w_qin[l];
                    end
                end
            end
        end
    end

    assign o_quo = r_quo[QB-1];
    assign o_neg = r_neg[QB-1];
    assign o_nz  = r_nz[QB-1];

endmodule

// ===== design/quaternion_vector_rotate.sv =====
// Channel   Direction  tdata (low bit up)              tuser
// s_axis    in         vec_x[15:0] vec_y vec_z         op
// m_axis    out        out_x[16:0] out_y out_z, pad    norm_zero
// cfg       in         index 0..3 = quat_w, x, y, z     -
//
// One word per cycle unless output back-pressure stalls the pipeline. The
// pipeline has four arithmetic stages, eighteen stages of the shared-divisor
// restoring divider (one quotient bit each) and a rounding and saturation stage.
// Reset is synchronous and clears the valid bits and the quaternion to identity.
// Each stage holds only while it is full and the one after it holds, so
// bubbles close up and a stalled output leaves earlier stages free to fill.
module quaternion_vector_rotate (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // vec_x, vec_y, vec_z
    input  logic [0:0]  s_axis_tuser,   // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // out_x, out_y, out_z, zero pad
    output logic [0:0]  m_axis_tuser    // norm_zero
);
    import qvr_pkg::*;

    localparam int NS = 4 + QB + 1;

    logic signed [VW-1:0] r_qw, r_qx, r_qy, r_qz;
    logic [NS-1:0] r_vld;
    logic [NS:0]   w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qw <= QUAT_W_RST;
            r_qx <= '0;
            r_qy <= '0;
            r_qz <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_QW: r_qw <= i_cfg_data;
                REG_QX: r_qx <= i_cfg_data;
                REG_QY: r_qy <= i_cfg_data;
                REG_QZ: r_qz <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        w_ce[NS] = m_axis_tready;
        for (int i = NS-1; i >= 0; i--) begin
            w_ce[i] = !r_vld[i] || w_ce[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (w_ce[i]) begin
                    r_vld[i] <= (i == 0) ? s_axis_tvalid : r_vld[(i == 0) ? 0 : i-1];
                end
            end
        end
    end

    assign s_axis_tready = w_ce[0];
    assign m_axis_tvalid = r_vld[NS-1];

    logic signed [VW-1:0] w_vx, w_vy, w_vz;
    logic signed [QW-1:0] w_ux, w_uy, w_uz;
    assign w_vx = s_axis_tdata[15:0];
    assign w_vy = s_axis_tdata[31:16];
    assign w_vz = s_axis_tdata[47:32];
    assign w_ux = s_axis_tuser[0] ? -QW'(r_qx) : QW'(r_qx);
    assign w_uy = s_axis_tuser[0] ? -QW'(r_qy) : QW'(r_qy);
    assign w_uz = s_axis_tuser[0] ? -QW'(r_qz) : QW'(r_qz);

    logic signed [PW-1:0] r1_xvx, r1_yvy, r1_zvz, r1_yvz, r1_zvy;
    logic signed [PW-1:0] r1_zvx, r1_xvz, r1_xvy, r1_yvx;
    logic signed [PW-1:0] r1_ww, r1_xx, r1_yy, r1_zz;
    logic signed [VW-1:0] r1_w, r1_vx, r1_vy, r1_vz;
    logic signed [QW-1:0] r1_ux, r1_uy, r1_uz;

    always_ff @(posedge i_clk) begin
        if (w_ce[0]) begin
            r1_xvx <= w_ux * w_vx;
            r1_yvy <= w_uy * w_vy;
            r1_zvz <= w_uz * w_vz;
            r1_yvz <= w_uy * w_vz;
            r1_zvy <= w_uz * w_vy;
            r1_zvx <= w_uz * w_vx;
            r1_xvz <= w_ux * w_vz;
            r1_xvy <= w_ux * w_vy;
            r1_yvx <= w_uy * w_vx;
            r1_ww  <= PW'(r_qw * r_qw);
            r1_xx  <= PW'(r_qx * r_qx);
            r1_yy  <= PW'(r_qy * r_qy);
            r1_zz  <= PW'(r_qz * r_qz);
            r1_w   <= r_qw;
            r1_vx  <= w_vx;
            r1_vy  <= w_vy;
            r1_vz  <= w_vz;
            r1_ux  <= w_ux;
            r1_uy  <= w_uy;
            r1_uz  <= w_uz;
        end
    end

    logic signed [DSW-1:0] r2_d;
    logic signed [CW-1:0]  r2_cx, r2_cy, r2_cz;
    logic signed [NW-1:0]  r2_k, r2_n;
    logic signed [VW-1:0]  r2_w, r2_vx, r2_vy, r2_vz;
    logic signed [QW-1:0]  r2_ux, r2_uy, r2_uz;

    always_ff @(posedge i_clk) begin
        if (w_ce[1]) begin
            r2_d  <= DSW'(r1_xvx) + DSW'(r1_yvy) + DSW'(r1_zvz);
            r2_cx <= CW'(r1_yvz) - CW'(r1_zvy);
            r2_cy <= CW'(r1_zvx) - CW'(r1_xvz);
            r2_cz <= CW'(r1_xvy) - CW'(r1_yvx);
            r2_k  <= NW'(r1_ww) - NW'(r1_xx) - NW'(r1_yy) - NW'(r1_zz);
            r2_n  <= NW'(r1_ww) + NW'(r1_xx) + NW'(r1_yy) + NW'(r1_zz);
            r2_w  <= r1_w;
            r2_vx <= r1_vx;
            r2_vy <= r1_vy;
            r2_vz <= r1_vz;
            r2_ux <= r1_ux;
            r2_uy <= r1_uy;
            r2_uz <= r1_uz;
        end
    end

    logic signed [M2W-1:0] r3_kv [LANES];
    logic signed [M2W-1:0] r3_du [LANES];
    logic signed [M2W-1:0] r3_wc [LANES];
    logic signed [NW-1:0]  r3_n;

    always_ff @(posedge i_clk) begin
        if (w_ce[2]) begin
            r3_kv[0] <= M2W'(r2_k * r2_vx);
            r3_kv[1] <= M2W'(r2_k * r2_vy);
            r3_kv[2] <= M2W'(r2_k * r2_vz);
            r3_du[0] <= M2W'(r2_d * r2_ux);
            r3_du[1] <= M2W'(r2_d * r2_uy);
            r3_du[2] <= M2W'(r2_d * r2_uz);
            r3_wc[0] <= M2W'(r2_w * r2_cx);
            r3_wc[1] <= M2W'(r2_w * r2_cy);
            r3_wc[2] <= M2W'(r2_w * r2_cz);
            r3_n     <= r2_n;
        end
    end

    t_rem             r4_num [LANES];
    logic [DW-1:0]    r4_den;
    logic [LANES-1:0] r4_neg;
    logic             r4_nz;
    logic signed [SW-1:0] w_p [LANES];
    logic [SW-1:0]        w_mag [LANES];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_p[l]   = SW'(r3_kv[l]) + (SW'(r3_du[l]) <<< 1) + (SW'(r3_wc[l]) <<< 1);
            w_mag[l] = w_p[l][SW-1] ? SW'(-w_p[l]) : SW'(w_p[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce[3]) begin
            for (int l = 0; l < LANES; l++) begin
                r4_num[l] <= (AW'(w_mag[l]) << 1) + AW'(unsigned'(r3_n));
                r4_neg[l] <= w_p[l][SW-1];
            end
            r4_den <= DW'(unsigned'(r3_n)) << 1;
            r4_nz  <= (r3_n == '0);
        end
    end

    t_quo             w_quo [LANES];
    logic [LANES-1:0] w_dneg;
    logic             w_dnz;

    qvr_divider u_div (
        .i_clk (i_clk),
        .i_ce  (w_ce[4 +: QB]),
        .i_num (r4_num),
        .i_den (r4_den),
        .i_neg (r4_neg),
        .i_nz  (r4_nz),
        .o_quo (w_quo),
        .o_neg (w_dneg),
        .o_nz  (w_dnz)
    );

    logic [OW-1:0] r5_out [LANES];
    logic          r5_nz;

    always_ff @(posedge i_clk) begin
        if (w_ce[NS-1]) begin
            r5_nz <= w_dnz;
            for (int l = 0; l < LANES; l++) begin
                if (w_dnz) begin
                    r5_out[l] <= '0;
                end else if (w_dneg[l]) begin
                    r5_out[l] <= (w_quo[l] > t_quo'(65536)) ? OW'(17'h10000)
                                                            : OW'(-w_quo[l]);
                end else begin
                    r5_out[l] <= (w_quo[l] > t_quo'(65535)) ? OW'(17'h0FFFF)
                                                            : OW'(w_quo[l]);
                end
            end
        end
    end

    assign m_axis_tdata = {5'b0, r5_out[2], r5_out[1], r5_out[0]};
    assign m_axis_tuser = r5_nz;

    a_nz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("norm_zero word carries nonzero components");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline not empty after reset");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (&r_vld) && !m_axis_tready)
        else $error("input stalled while pipeline has room");

endmodule

// ===== dv/quaternion_vector_rotate_test.sv =====
module quaternion_vector_rotate_test;
    import qvr_pkg::*;

    typedef struct packed {
        logic        op;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] vz;
    } vec_word_t;

    typedef struct packed {
        logic [16:0] rx;
        logic [16:0] ry;
        logic [16:0] rz;
        logic        nz;
    } rot_word_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // vec_x, vec_y, vec_z
    logic [0:0]  s_axis_tuser;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // out_x, out_y, out_z, zero pad
    logic [0:0]  m_axis_tuser;   // norm_zero

    quaternion_vector_rotate i_dut (.*);

    vec_word_t   pending_vecs[$];
    rot_word_t   expected_rots[$];
    logic [15:0] quat[4];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_request;
    int          hold_left;
    int          stuck_cycles;
    int          errors;
    bit          vec_sent;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [16:0] div_round_sat(longint p, longint n);
        longint mag;
        longint q;
        mag = (p < 0) ? -p : p;
        q = (2 * mag + n) / (2 * n);
        if (p < 0) begin
            return (q > 65536) ? -17'sd65536 : 17'(-q);
        end
        return (q > 65535) ? 17'sd65535 : 17'(q);
    endfunction

    function automatic rot_word_t rotate_vec(vec_word_t v);
        longint w, x, y, z, vx, vy, vz, n, k, d, cx, cy, cz;
        rot_word_t r;
        w = longint'($signed(quat[REG_QW]));
        x = longint'($signed(quat[REG_QX]));
        y = longint'($signed(quat[REG_QY]));
        z = longint'($signed(quat[REG_QZ]));
        vx = longint'($signed(v.vx));
        vy = longint'($signed(v.vy));
        vz = longint'($signed(v.vz));
        if (v.op) begin
            x = -x;
            y = -y;
            z = -z;
        end
        n = w * w + x * x + y * y + z * z;
        if (n == 0) begin
            r = '{rx: '0, ry: '0, rz: '0, nz: 1'b1};
            return r;
        end
        k = w * w - (x * x + y * y + z * z);
        d = x * vx + y * vy + z * vz;
        cx = y * vz - z * vy;
        cy = z * vx - x * vz;
        cz = x * vy - y * vx;
        r.rx = div_round_sat(k * vx + 2 * d * x + 2 * w * cx, n);
        r.ry = div_round_sat(k * vy + 2 * d * y + 2 * w * cy, n);
        r.rz = div_round_sat(k * vz + 2 * d * z + 2 * w * cz, n);
        r.nz = 1'b0;
        return r;
    endfunction

    always @(posedge i_clk) begin
        rot_word_t want;
        rot_word_t got;
        vec_word_t v;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                v = '{op: s_axis_tuser[0], vx: s_axis_tdata[15:0],
                      vy: s_axis_tdata[31:16], vz: s_axis_tdata[47:32]};
                expected_rots.push_back(rotate_vec(v));
                vec_sent = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{rx: m_axis_tdata[16:0], ry: m_axis_tdata[33:17],
                        rz: m_axis_tdata[50:34], nz: m_axis_tuser[0]};
                if (expected_rots.size() == 0) begin
                    $display("%0t: unexpected word x=%h y=%h z=%h nz=%b", $time,
                             got.rx, got.ry, got.rz, got.nz);
                    errors++;
                end else begin
                    want = expected_rots.pop_front();
                    if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz
                        || got.nz !== want.nz || m_axis_tdata[55:51] !== '0) begin
                        $display("%0t: expected x=%h y=%h z=%h nz=%b, got x=%h y=%h z=%h nz=%b",
                                 $time, want.rx, want.ry, want.rz, want.nz,
                                 got.rx, got.ry, got.rz, got.nz);
                        errors++;
                    end
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (pending_vecs.size() == 0 && expected_rots.size() == 0)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= 3000) begin
                    $display("quaternion_vector_rotate_test failed");
                    $finish;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || vec_sent) begin
            if (vec_sent) begin
                void'(pending_vecs.pop_front());
                vec_sent = 1'b0;
            end
            if (pending_vecs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {pending_vecs[0].vz, pending_vecs[0].vy, pending_vecs[0].vx};
                s_axis_tuser <= pending_vecs[0].op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_quat(logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
                              logic [15:0] qz);
        logic [15:0] vals[4];
        vals = '{qw, qx, qy, qz};
        for (int i = 0; i < 4; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= t_reg_idx'(i);
            i_cfg_data <= vals[i];
            quat[i] = vals[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        wait (pending_vecs.size() == 0 && expected_rots.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_comp();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic vec_word_t pick_vec();
        vec_word_t v;
        v.op = 1'($urandom_range(1));
        v.vx = pick_comp();
        v.vy = pick_comp();
        v.vz = ($urandom_range(5) == 0) ? 16'h0000 : pick_comp();
        return v;
    endfunction

    initial begin
        logic [15:0] extremes[4];
        logic [15:0] cfg[10][4];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_QW;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 0;
        hold_left = 0;
        stuck_cycles = 0;
        errors = 0;
        vec_sent = 1'b0;
        quat = '{QUAT_W_RST, 16'h0, 16'h0, 16'h0};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Identity after reset, then a quarter turn about x, with field extremes.
        extremes = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        for (int i = 0; i < 12; i++) begin
            pending_vecs.push_back('{op: i[0], vx: extremes[i % 4],
                                     vy: extremes[(i + 1) % 4], vz: extremes[(i / 4) % 4]});
        end
        wait_drained();
        write_quat(16'd11585, 16'd11585, 16'd0, 16'd0);
        for (int i = 0; i < 12; i++) begin
            pending_vecs.push_back('{op: i[0], vx: extremes[(i + 2) % 4],
                                     vy: extremes[i % 4], vz: extremes[(i / 3) % 4]});
        end
        wait_drained();

        cfg = '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000},
                '{16'h8000, 16'h8000, 16'h8000, 16'h8000},
                '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
                '{16'h8000, 16'h7fff, 16'h0000, 16'h8000},
                '{16'h0001, 16'h0001, 16'hffff, 16'h0000},
                '{16'h0000, 16'h0000, 16'h0000, 16'h0001},
                '{16'd16384, 16'h0000, 16'h0000, 16'h0000},
                '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)},
                '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)},
                '{16'd8192, 16'd8192, 16'd8192, 16'd8192}};
        for (int ph = 0; ph < 10; ph++) begin
            write_quat(cfg[ph][0], cfg[ph][1], cfg[ph][2], cfg[ph][3]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            if (ph == 4) begin
                send_idle_pct = 0;
                hold_request = 1;
            end
            for (int i = 0; i < 173; i++) pending_vecs.push_back(pick_vec());
            wait_drained();
        end

        if (errors == 0) begin
            $display("quaternion_vector_rotate_test passed");
        end else begin
            $display("quaternion_vector_rotate_test failed");
        end
        $finish;
    end
endmodule

// ===== quaternion_vector_rotate.f =====
design/qvr_pkg.sv
design/qvr_divider.sv
design/quaternion_vector_rotate.sv
dv/quaternion_vector_rotate_test.sv
